>>> hw/rtl/u8tc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8tc_pkg;

	// default depth of the job queue between front and back
	localparam int unsigned QDEPTH_DFLT = 4;

	typedef enum logic [3:0] {
		ERR_NONE       = 4'd0,
		ERR_U32_ODD    = 4'd1,
		ERR_U32_RANGE  = 4'd2,
		ERR_U16_ODD    = 4'd3,
		ERR_HIGH_END   = 4'd4,
		ERR_BAD_LOW    = 4'd5,
		ERR_LONE_LOW   = 4'd6,
		ERR_NONCHAR    = 4'd7,
		ERR_NO_MARK    = 4'd8
	} u8tc_err_t;

	// work for one accepted byte: up to two elements, then an optional marker
	typedef struct packed {
		logic        e0v;
		logic        e0raw;
		logic [20:0] e0val;
		logic        e1v;
		logic        e1raw;
		logic [20:0] e1val;
		u8tc_err_t   err;
		logic        last;
	} u8tc_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} u8tc_qstat_t;

endpackage

`default_nettype wire

>>> hw/rtl/u8tc_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface u8tc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/u8tc_utf8_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface u8tc_utf8_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;
	logic [3:0] error_code;

	modport source (output valid, output out_byte, output out_valid, output out_last,
		output error_code, input ready);
	modport sink (input valid, input out_byte, input out_valid, input out_last,
		input error_code, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/u8tc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u8tc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	u8tc_byte_if.sink             raw,
	input  u8tc_pkg::u8tc_qstat_t qstat,
	output logic                  push,
	output u8tc_pkg::u8tc_job_t   job
);
	import u8tc_pkg::*;

	typedef enum logic [6:0] {
		MODE_DETECT = 7'b0000001,
		MODE_UTF8   = 7'b0000010,
		MODE_U16LE  = 7'b0000100,
		MODE_U16BE  = 7'b0001000,
		MODE_U32LE  = 7'b0010000,
		MODE_U32BE  = 7'b0100000,
		MODE_AMBIG  = 7'b1000000
	} mode_t;

	localparam logic [7:0]  BYTE_FF = 8'hFF;
	localparam logic [7:0]  BYTE_FE = 8'hFE;
	localparam logic [7:0]  BYTE_EF = 8'hEF;
	localparam logic [7:0]  BYTE_BB = 8'hBB;
	localparam logic [7:0]  BYTE_BF = 8'hBF;
	localparam logic [31:0] CP_MAX  = 32'h0010_FFFF;
	localparam logic [5:0]  TAG_HI  = 6'b110110;
	localparam logic [5:0]  TAG_LO  = 6'b110111;
	localparam logic [10:0] PLANE_OFS = 11'h040;

	mode_t       mode_q, mode_d;
	logic [7:0]  lb_q [3];
	logic [1:0]  cnt_q, cnt_d;
	logic [23:0] acc_q, acc_d;
	logic [1:0]  fill_q, fill_d;
	logic [9:0]  hs_q, hs_d;
	logic        pend_q, pend_d;
	logic        halted_q;

	logic        live;
	logic [7:0]  b;
	logic        fin;
	logic        e0v, e0raw, e1v, e1raw;
	logic [20:0] e0val, e1val;
	logic [20:0] ucp;
	logic        uemit;
	u8tc_err_t   err;
	logic        last;
	logic        take_unit;
	logic [15:0] code_unit;
	logic [31:0] word32;

	assign raw.ready = halted_q || !qstat.full;
	assign live      = raw.valid && raw.ready && !halted_q;
	assign b         = raw.in_byte;
	assign fin       = raw.in_last;

	always_comb begin
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		acc_d     = acc_q;
		fill_d    = fill_q;
		hs_d      = hs_q;
		pend_d    = pend_q;
		e0v       = 1'b0;
		e0raw     = 1'b0;
		e0val     = '0;
		e1v       = 1'b0;
		e1raw     = 1'b0;
		e1val     = '0;
		err       = ERR_NONE;
		last      = 1'b0;
		take_unit = 1'b0;
		code_unit = '0;
		word32    = '0;
		ucp       = '0;
		uemit     = 1'b0;

		unique case (mode_q)
			MODE_DETECT: begin
				cnt_d = cnt_q + 2'd1;
				unique case (cnt_q)
					2'd0: begin
						// one-byte file goes through untouched
						if (fin) begin
							mode_d = MODE_UTF8;
							e0v    = 1'b1;
							e0raw  = 1'b1;
							e0val  = {13'd0, b};
						end
					end
					2'd1: begin
						priority if (lb_q[0] == BYTE_FF && b == BYTE_FE) begin
							if (fin) begin
								mode_d = MODE_U16LE;
							end
						end else if (lb_q[0] == BYTE_FE && b == BYTE_FF) begin
							mode_d = MODE_U16BE;
						end else if (b == 8'h00 && lb_q[0] != 8'h00) begin
							// first code point is known either way
							mode_d = fin ? MODE_U16LE : MODE_AMBIG;
							e0v    = 1'b1;
							e0val  = {13'd0, lb_q[0]};
						end else if (lb_q[0] == 8'h00 && b == 8'h00) begin
							if (fin) begin
								mode_d = MODE_U16LE;
								e0v    = 1'b1;
							end
						end else if (lb_q[0] == 8'h00) begin
							mode_d = MODE_U16BE;
							e0v    = 1'b1;
							e0val  = {13'd0, b};
						end else if (lb_q[0] == BYTE_EF && b == BYTE_BB && !fin) begin
							mode_d = MODE_DETECT;
						end else if (lb_q[0][7]) begin
							err = ERR_NO_MARK;
						end else begin
							mode_d = MODE_UTF8;
							e0v    = 1'b1;
							e0raw  = 1'b1;
							e0val  = {13'd0, lb_q[0]};
							e1v    = 1'b1;
							e1raw  = 1'b1;
							e1val  = {13'd0, b};
						end
					end
					2'd2: begin
						priority if (lb_q[0] == BYTE_FF) begin
							if (b != 8'h00 || fin) begin
								mode_d     = MODE_U16LE;
								fill_d     = 2'd1;
								acc_d[7:0] = b;
							end
						end else if (lb_q[0] == BYTE_EF) begin
							if (b == BYTE_BF) begin
								mode_d = MODE_UTF8;
							end else begin
								err = ERR_NO_MARK;
							end
						end else if (fin) begin
							// zero unit, then a dangling byte
							mode_d     = MODE_U16LE;
							e0v        = 1'b1;
							fill_d     = 2'd1;
							acc_d[7:0] = b;
						end else begin
							// leading zero pair, the fourth byte settles it
							mode_d = MODE_DETECT;
						end
					end
					default: begin
						priority if (lb_q[0] == BYTE_FF) begin
							if (b == 8'h00) begin
								mode_d = MODE_U32LE;
								fill_d = 2'd0;
							end else begin
								mode_d    = MODE_U16LE;
								take_unit = 1'b1;
								code_unit = {b, lb_q[2]};
							end
						end else if (lb_q[2] == BYTE_FE && b == BYTE_FF) begin
							mode_d = MODE_U32BE;
						end else if (lb_q[2] == 8'h00 && b == 8'h00) begin
							mode_d = MODE_U32LE;
							e0v    = 1'b1;
							e0val  = {5'd0, lb_q[1], lb_q[0]};
						end else if (lb_q[2] == 8'h00) begin
							// leading two bytes are zero on this path
							mode_d = MODE_U32BE;
							e0v    = 1'b1;
							e0val  = {5'd0, lb_q[2], b};
						end else begin
							mode_d    = MODE_U16LE;
							e0v       = 1'b1;
							e0val     = {5'd0, lb_q[1], lb_q[0]};
							take_unit = 1'b1;
							code_unit = {b, lb_q[2]};
						end
					end
				endcase
			end
			MODE_AMBIG: begin
				if (cnt_q != 2'd3) begin
					if (b != 8'h00 || fin) begin
						mode_d     = MODE_U16LE;
						fill_d     = 2'd1;
						acc_d[7:0] = b;
					end else begin
						cnt_d = 2'd3;
					end
				end else if (b == 8'h00) begin
					mode_d = MODE_U32LE;
					fill_d = 2'd0;
				end else begin
					mode_d    = MODE_U16LE;
					take_unit = 1'b1;
					code_unit = {b, 8'h00};
				end
			end
			MODE_UTF8: begin
				e0v   = 1'b1;
				e0raw = 1'b1;
				e0val = {13'd0, b};
			end
			MODE_U16LE, MODE_U16BE: begin
				if (fill_q == 2'd0) begin
					acc_d[7:0] = b;
					fill_d     = 2'd1;
				end else begin
					fill_d    = 2'd0;
					take_unit = 1'b1;
					code_unit = (mode_q == MODE_U16LE) ? {b, acc_q[7:0]} : {acc_q[7:0], b};
				end
			end
			MODE_U32LE, MODE_U32BE: begin
				if (fill_q != 2'd3) begin
					if (mode_q == MODE_U32LE) begin
						acc_d[{fill_q, 3'b000} +: 8] = b;
					end else begin
						acc_d = {acc_q[15:0], b};
					end
					fill_d = fill_q + 2'd1;
				end else begin
					fill_d = 2'd0;
					word32 = (mode_q == MODE_U32LE) ? {b, acc_q} : {acc_q, b};
					if (word32 > CP_MAX) begin
						err = ERR_U32_RANGE;
					end else begin
						e0v   = 1'b1;
						e0val = word32[20:0];
					end
				end
			end
			default: begin
				mode_d = mode_q;
			end
		endcase

		// one UTF-16 code unit at most per byte
		if (take_unit) begin
			priority if (pend_q) begin
				if (code_unit[15:10] == TAG_LO) begin
					pend_d = 1'b0;
					ucp    = {({1'b0, hs_q} + PLANE_OFS), code_unit[9:0]};
					uemit  = 1'b1;
				end else begin
					err = ERR_BAD_LOW;
				end
			end else if (code_unit[15:10] == TAG_HI) begin
				hs_d   = code_unit[9:0];
				pend_d = 1'b1;
			end else if (code_unit[15:10] == TAG_LO) begin
				err = ERR_LONE_LOW;
			end else if (code_unit[15:1] == 15'h7FFF) begin
				err = ERR_NONCHAR;
			end else begin
				ucp   = {5'd0, code_unit};
				uemit = 1'b1;
			end
			if (uemit) begin
				if (e0v) begin
					e1v   = 1'b1;
					e1val = ucp;
				end else begin
					e0v   = 1'b1;
					e0val = ucp;
				end
			end
		end

		// end-of-file checks, then back to detection when no error is found
		if (fin && err == ERR_NONE) begin
			if (mode_d == MODE_U16LE || mode_d == MODE_U16BE) begin
				if (fill_d != 2'd0) begin
					err = ERR_U16_ODD;
				end else if (pend_d) begin
					err = ERR_HIGH_END;
				end
			end else if (mode_d == MODE_U32LE || mode_d == MODE_U32BE) begin
				if (fill_d != 2'd0) begin
					err = ERR_U32_ODD;
				end
			end
			if (err == ERR_NONE) begin
				last   = 1'b1;
				mode_d = MODE_DETECT;
				cnt_d  = 2'd0;
				fill_d = 2'd0;
				pend_d = 1'b0;
				hs_d   = '0;
			end
		end
	end

	assign push      = live && (e0v || err != ERR_NONE || last);
	assign job.e0v   = e0v;
	assign job.e0raw = e0raw;
	assign job.e0val = e0val;
	assign job.e1v   = e1v;
	assign job.e1raw = e1raw;
	assign job.e1val = e1val;
	assign job.err   = err;
	assign job.last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DETECT;
			cnt_q    <= '0;
			fill_q   <= '0;
			hs_q     <= '0;
			pend_q   <= 1'b0;
			halted_q <= 1'b0;
		end else if (live) begin
			mode_q   <= mode_d;
			cnt_q    <= cnt_d;
			fill_q   <= fill_d;
			hs_q     <= hs_d;
			pend_q   <= pend_d;
			halted_q <= (err != ERR_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (live) begin
			acc_q <= acc_d;
			if (mode_q == MODE_DETECT && cnt_q != 2'd3) begin
				lb_q[cnt_q] <= b;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/u8tc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module u8tc_fifo #(
	parameter int unsigned DEPTH = u8tc_pkg::QDEPTH_DFLT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  u8tc_pkg::u8tc_job_t   wdata,
	input  logic                  pop,
	output u8tc_pkg::u8tc_job_t   head,
	output u8tc_pkg::u8tc_qstat_t qstat
);
	import u8tc_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	u8tc_job_t     slot_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign head        = slot_q[rp_q];
	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == LAST_PTR) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == LAST_PTR) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/u8tc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u8tc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  u8tc_pkg::u8tc_job_t   head,
	input  u8tc_pkg::u8tc_qstat_t qstat,
	output logic                  pop,
	u8tc_utf8_if.source           utf8
);
	import u8tc_pkg::*;

	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	function automatic logic [2:0] cp_len(input logic [20:0] v, input logic raw_b);
		logic [2:0] n;
		priority if (raw_b || v[20:7] == '0) begin
			n = 3'd1;
		end else if (v[20:11] == '0) begin
			n = 3'd2;
		end else if (v[20:16] == '0) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	function automatic logic [7:0] enc_byte(input logic [20:0] v, input logic [2:0] n,
		input logic [1:0] k);
		logic [7:0] r;
		unique case (n)
			3'd2: begin
				r = (k == 2'd0) ? (LEAD2 | {3'b000, v[10:6]}) : (CONT | {2'b00, v[5:0]});
			end
			3'd3: begin
				unique case (k)
					2'd0:    r = LEAD3 | {4'b0000, v[15:12]};
					2'd1:    r = CONT | {2'b00, v[11:6]};
					default: r = CONT | {2'b00, v[5:0]};
				endcase
			end
			3'd4: begin
				unique case (k)
					2'd0:    r = LEAD4 | {5'b00000, v[20:18]};
					2'd1:    r = CONT | {2'b00, v[17:12]};
					2'd2:    r = CONT | {2'b00, v[11:6]};
					default: r = CONT | {2'b00, v[5:0]};
				endcase
			end
			default: begin
				r = v[7:0];
			end
		endcase
		return r;
	endfunction

	logic [1:0] s_q;
	logic       ov_q;
	logic [7:0] obyte_q;
	logic       ovalid_q;
	logic       olast_q;
	logic [3:0] ocode_q;

	logic [2:0] len0, len1, dcnt, total, last_idx;
	logic [3:0] sum;
	logic       mark, is_data, in0, load, at_end;
	logic [1:0] k;
	logic [7:0] dbyte;

	always_comb begin
		len0     = head.e0v ? cp_len(head.e0val, head.e0raw) : 3'd0;
		len1     = head.e1v ? cp_len(head.e1val, head.e1raw) : 3'd0;
		sum      = {1'b0, len0} + {1'b0, len1};
		// at most four words leave per byte
		dcnt     = (sum > 4'd4) ? 3'd4 : sum[2:0];
		mark     = (head.err != ERR_NONE && dcnt != 3'd4) || (head.last && dcnt == 3'd0);
		total    = dcnt + {2'b00, mark};
		last_idx = total - 3'd1;
		is_data  = {1'b0, s_q} < dcnt;
		in0      = {1'b0, s_q} < len0;
		k        = in0 ? s_q : s_q - len0[1:0];
		dbyte    = in0 ? enc_byte(head.e0val, len0, k) : enc_byte(head.e1val, len1, k);
		at_end   = ({1'b0, s_q} == last_idx);
		load     = !qstat.empty && (!ov_q || utf8.ready);
	end

	assign pop = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q  <= '0;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				s_q  <= at_end ? 2'd0 : s_q + 2'd1;
				ov_q <= 1'b1;
			end else if (utf8.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q  <= is_data ? dbyte : 8'h00;
			ovalid_q <= is_data;
			olast_q  <= is_data ? (head.last && at_end) : 1'b1;
			ocode_q  <= is_data ? ERR_NONE : head.err;
		end
	end

	assign utf8.valid      = ov_q;
	assign utf8.out_byte   = obyte_q;
	assign utf8.out_valid  = ovalid_q;
	assign utf8.out_last   = olast_q;
	assign utf8.error_code = ocode_q;

endmodule

`default_nettype wire

>>> hw/rtl/utf16_utf32_to_utf8_transcoder.sv
`timescale 1ns / 1ps
`default_nettype none

// utf16/utf32 to utf8 transcoder with byte-order-mark detection
//
// raw:  one source byte per word (in_byte), in_last flags the final byte of a file
// utf8: result words; out_valid=1 carries a utf8 byte, out_valid=0 is an end or
//       error marker, out_last marks the final word of a file or the error word
//
// data path: a word caused by a byte passes through the job queue and then the
// output register before it appears on utf8. throughput: raw takes one byte per
// cycle while the job queue (QDEPTH entries) has room; each byte yields zero to
// four words and the output register drives one word per cycle while the receiver
// is ready, so the single output word per cycle bounds the sustained byte rate
// when bytes yield more than one word.
//
// reset: detection restarts, the queue empties, no word is pending.
// receiver stall: the output register holds its word, jobs pile up in the
// queue and raw.ready drops once it is full. after a byte that raises an error
// the block keeps raw.ready high and drops every byte until the next reset.
module utf16_utf32_to_utf8_transcoder #(
	parameter int unsigned QDEPTH = u8tc_pkg::QDEPTH_DFLT
) (
	input logic         clk,
	input logic         arst_n,
	u8tc_byte_if.sink   raw,
	u8tc_utf8_if.source utf8
);
	import u8tc_pkg::*;

	// front classifies bytes and builds one job per byte that yields words
	logic        push;
	logic        pop;
	u8tc_job_t   job;
	u8tc_job_t   head;
	u8tc_qstat_t qstat;

	u8tc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.qstat  (qstat),
		.push   (push),
		.job    (job)
	);

	// short queue lets the front keep taking bytes while the back is busy
	u8tc_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// back emits each job as utf8 bytes and markers, one word per cycle unless stalled
	u8tc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.utf8   (utf8)
	);

endmodule

`default_nettype wire

>>> hw/rtl/u8tc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module u8tc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       utf8_valid,
	input logic       utf8_ready,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic       out_last,
	input logic [3:0] error_code
);
	import u8tc_pkg::*;

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		utf8_valid && !utf8_ready |=> utf8_valid &&
		$stable({out_byte, out_valid, out_last, error_code}))
		else $error("output word changed under stall");

	// data words never carry a code
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		utf8_valid && out_valid |-> error_code == ERR_NONE)
		else $error("data word with error code");

	// markers close the file and carry no byte
	a_mark: assert property (@(posedge clk) disable iff (!arst_n)
		utf8_valid && !out_valid |-> out_last && out_byte == 8'h00)
		else $error("malformed marker word");

	// nothing follows an error word
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		utf8_valid && utf8_ready && error_code != ERR_NONE |=> !utf8_valid)
		else $error("word after error");

endmodule

bind utf16_utf32_to_utf8_transcoder u8tc_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.utf8_valid (utf8.valid),
	.utf8_ready (utf8.ready),
	.out_byte   (utf8.out_byte),
	.out_valid  (utf8.out_valid),
	.out_last   (utf8.out_last),
	.error_code (utf8.error_code)
);

`default_nettype wire
